// ----- rtl/mcbb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mcbb_pkg;

    // Search width: vertices handled by the store and the sequencer.
    localparam int MAX_V  = 16;
    // Bits of a vertex number.
    localparam int VID_W  = $clog2(MAX_V);
    // Bits of a depth, a size or a vertex bound (0 .. MAX_V).
    localparam int DEP_W  = $clog2(MAX_V + 1);
    // Fixed field widths.
    localparam int ROW_W  = 16;
    localparam int CFG_W  = 5;
    localparam int SIZE_W = 5;
    localparam int NODE_W = 16;

    typedef logic [MAX_V-1:0] vmask_t;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_RUN  = 1'b1
    } opcode_t;

    // Result of the shared row test for one candidate vertex.
    typedef struct packed {
        logic joins;   // candidate row marks every member
        logic col_ok;  // every member row marks the candidate
    } test_t;

    // Sequencer status toward the top level.
    typedef struct packed {
        logic idle;
        logic res_valid;
    } seq_stat_t;

    function automatic vmask_t vbit(input logic [VID_W-1:0] v);
        vbit = vmask_t'(1) << v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/mcbb_adj.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Adjacency row store plus the shared membership test unit.
module mcbb_adj (
    input  wire logic                        aclk,
    input  wire logic                        wr_en,
    input  wire logic [mcbb_pkg::VID_W-1:0]  wr_idx,
    input  wire logic [mcbb_pkg::ROW_W-1:0]  wr_row,
    input  wire logic [mcbb_pkg::VID_W-1:0]  test_v,
    input  wire mcbb_pkg::vmask_t            members,
    output mcbb_pkg::test_t                  test
);
    import mcbb_pkg::*;

    vmask_t rows_reg [MAX_V];
    vmask_t col_bits;
    vmask_t cand_row;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            rows_reg[wr_idx] <= vmask_t'(wr_row);
        end
    end

    // column view: bit m is row m's mark for the candidate
    always_comb begin
        for (int m = 0; m < MAX_V; m++) begin
            col_bits[m] = rows_reg[m][test_v];
        end
    end

    assign cand_row    = rows_reg[test_v];
    assign test.joins  = ((cand_row & members) == members);
    assign test.col_ok = &(col_bits | ~members);

endmodule

`default_nettype wire

// ----- rtl/mcbb_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Depth-first search sequencer with an explicit member stack.
module mcbb_seq (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [mcbb_pkg::CFG_W-1:0]   vertex_count,
    input  wire logic                         out_free,
    input  wire mcbb_pkg::test_t              test,
    output logic [mcbb_pkg::VID_W-1:0]        test_v,
    output mcbb_pkg::vmask_t                  members,
    output mcbb_pkg::seq_stat_t               stat,
    output mcbb_pkg::vmask_t                  best_mask,
    output logic [mcbb_pkg::DEP_W-1:0]        best_size,
    output logic [mcbb_pkg::NODE_W-1:0]       nodes
);
    import mcbb_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ENTER,
        ST_POP,
        ST_FINISH
    } state_t;

    state_t                 state_reg,  state_next;
    logic [DEP_W-1:0]       depth_reg,  depth_next;
    logic [DEP_W-1:0]       v_reg,      v_next;
    logic [DEP_W-1:0]       n_reg,      n_next;
    vmask_t                 mask_reg,   mask_next;
    logic [DEP_W-1:0]       best_reg,   best_next;
    vmask_t                 bmask_reg,  bmask_next;
    logic [NODE_W-1:0]      cnt_reg,    cnt_next;
    logic [MAX_V:0]         cok_reg,    cok_next;
    logic [VID_W-1:0]       stack_reg [MAX_V];

    logic                   push;
    logic [VID_W-1:0]       top_v;
    logic [DEP_W:0]         bound;

    assign top_v = stack_reg[VID_W'(depth_reg - DEP_W'(1))];
    // set size plus untried vertices
    assign bound = {1'b0, depth_reg} + ({1'b0, n_reg} - {1'b0, v_reg});

    assign test_v  = v_reg[VID_W-1:0];
    assign members = mask_reg;

    always_comb begin
        state_next = state_reg;
        depth_next = depth_reg;
        v_next     = v_reg;
        n_next     = n_reg;
        mask_next  = mask_reg;
        best_next  = best_reg;
        bmask_next = bmask_reg;
        cnt_next   = cnt_reg;
        cok_next   = cok_reg;
        push       = 1'b0;
        stat.idle      = (state_reg == ST_IDLE);
        stat.res_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    n_next     = (vertex_count > CFG_W'(MAX_V)) ? DEP_W'(MAX_V)
                                                                : DEP_W'(vertex_count);
                    depth_next = '0;
                    v_next     = '0;
                    mask_next  = '0;
                    best_next  = '0;
                    bmask_next = '0;
                    cnt_next   = '0;
                    cok_next   = '0;
                    cok_next[0] = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (v_reg >= n_reg) begin
                    state_next = (depth_reg == '0) ? ST_FINISH : ST_POP;
                end else if (test.joins) begin
                    push       = 1'b1;
                    cok_next[depth_reg + DEP_W'(1)] = cok_reg[depth_reg] & test.col_ok;
                    mask_next  = mask_reg | vbit(v_reg[VID_W-1:0]);
                    depth_next = depth_reg + DEP_W'(1);
                    v_next     = v_reg + DEP_W'(1);
                    state_next = ST_ENTER;
                end else begin
                    v_next = v_reg + DEP_W'(1);
                end
            end
            ST_ENTER: begin
                if (cnt_reg != '1) begin
                    cnt_next = cnt_reg + NODE_W'(1);
                end
                if (bound <= {1'b0, best_reg}) begin
                    state_next = ST_POP;
                end else begin
                    if (cok_reg[depth_reg] && (depth_reg > best_reg)) begin
                        best_next  = depth_reg;
                        bmask_next = mask_reg;
                    end
                    state_next = (depth_reg >= DEP_W'(MAX_V)) ? ST_POP : ST_SCAN;
                end
            end
            ST_POP: begin
                mask_next  = mask_reg & ~vbit(top_v);
                v_next     = DEP_W'(top_v) + DEP_W'(1);
                depth_next = depth_reg - DEP_W'(1);
                state_next = ST_SCAN;
            end
            ST_FINISH: begin
                if (out_free) begin
                    stat.res_valid = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            depth_reg <= '0;
            v_reg     <= '0;
            n_reg     <= '0;
            mask_reg  <= '0;
            best_reg  <= '0;
            bmask_reg <= '0;
            cnt_reg   <= '0;
            cok_reg   <= '0;
        end else begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            v_reg     <= v_next;
            n_reg     <= n_next;
            mask_reg  <= mask_next;
            best_reg  <= best_next;
            bmask_reg <= bmask_next;
            cnt_reg   <= cnt_next;
            cok_reg   <= cok_next;
        end
    end

    // member stack: every read slot is written by a push first
    always_ff @(posedge aclk) begin
        if (push) begin
            stack_reg[depth_reg[VID_W-1:0]] <= v_reg[VID_W-1:0];
        end
    end

    assign best_mask = bmask_reg;
    assign best_size = best_reg;
    assign nodes     = cnt_reg;

endmodule

`default_nettype wire

// ----- rtl/max_clique_branch_bound_top.sv -----
// Load word: accepted while the sequencer is idle, no result word; loads may come back to back.
// Run word: the single-step sequencer scans candidate vertices one at a time, enters and later pops each search node,
//   closes the scan of each node not cut by the bound or the 16-member limit,
//   then closes the start-vertex scan and finishes once the output register is free.
// s_tready is low for the whole run and while a finished result waits on a full output reg.
// Reset (aresetn low, synchronous): idle, no result pending, vertex_count = 16.
`timescale 1ns / 1ps
`default_nettype none

module max_clique_branch_bound_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // config: vertex_count
    input  wire logic        cfg_we,
    input  wire logic [4:0]  cfg_wdata,
    // input words
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [3:0] row_index, [19:4] row_bits, rest zero
    input  wire logic [0:0]  s_tuser,   // [0] opcode
    // result words
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata    // [15:0] clique_mask, [20:16] clique_size,
                                        // [36:21] nodes_explored, rest zero
);
    import mcbb_pkg::*;

    logic [CFG_W-1:0]   vcount_reg;
    logic               m_valid_reg;
    logic [15:0]        m_mask_reg;
    logic [SIZE_W-1:0]  m_size_reg;
    logic [NODE_W-1:0]  m_nodes_reg;

    logic               s_acc;
    opcode_t            op;
    logic               out_free;
    test_t              test;
    seq_stat_t          stat;
    logic [VID_W-1:0]   test_v;
    vmask_t             members;
    vmask_t             best_mask;
    logic [DEP_W-1:0]   best_size;
    logic [NODE_W-1:0]  nodes;

    assign s_acc    = s_tvalid && s_tready;
    assign op       = opcode_t'(s_tuser[0]);
    // loads are taken any time the sequencer is idle; a finished result
    // may still be waiting in the output register
    assign s_tready = stat.idle;
    assign out_free = !m_valid_reg || m_tready;

    // config register; the user writes it only while idle, the block does not enforce this
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg <= CFG_W'(16);
        end else if (cfg_we) begin
            vcount_reg <= cfg_wdata;
        end
    end

    // row store and shared test unit
    mcbb_adj u_adj (
        .aclk    (aclk),
        .wr_en   (s_acc && (op == OP_LOAD)),
        .wr_idx  (VID_W'(s_tdata[3:0])),
        .wr_row  (s_tdata[19:4]),
        .test_v  (test_v),
        .members (members),
        .test    (test)
    );

    // search sequencer
    mcbb_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (s_acc && (op == OP_RUN)),
        .vertex_count (vcount_reg),
        .out_free     (out_free),
        .test         (test),
        .test_v       (test_v),
        .members      (members),
        .stat         (stat),
        .best_mask    (best_mask),
        .best_size    (best_size),
        .nodes        (nodes)
    );

    // output register: loaded when the sequencer finishes and the slot is free
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (stat.res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (stat.res_valid) begin
            m_mask_reg  <= 16'(best_mask);
            m_size_reg  <= SIZE_W'(best_size);
            m_nodes_reg <= nodes;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_nodes_reg, m_size_reg, m_mask_reg};

endmodule

`default_nettype wire

// ----- rtl/mcbb_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mcbb_chk (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [4:0]  cfg_wdata,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [23:0] s_tdata,
    input  wire logic [0:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [39:0] m_tdata
);

    // stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // mask population equals reported size
    a_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($countones(m_tdata[15:0]) == 32'(m_tdata[20:16])))
        else $error("clique size does not match mask");

    // a clique of size k needs at least k branches
    a_nodes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[36:21] >= 16'(m_tdata[20:16])))
        else $error("node count below clique size");

    // a run word makes the block busy
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] |=> !s_tready)
        else $error("input taken right after a run word");

endmodule

bind max_clique_branch_bound_top mcbb_chk u_chk (.*);

`default_nettype wire
